// ===== rtl/core/tmh_pkg.sv =====
// Shared types, sizes and codes of the timed-event min-heap.
`timescale 1ns / 1ps
package tmh_pkg;

    // Heap geometry
    localparam int CAPACITY = 64;
    localparam int ARITY    = 4;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int CH_W     = IDX_W + $clog2(ARITY) + 1;

    // Field widths
    localparam int DL_W = 32;
    localparam int HD_W = 16;

    // Input kind codes
    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_POLL   = 1'b1;

    // One heap slot: deadline plus opaque handle
    typedef struct packed {
        logic [DL_W-1:0] deadline;
        logic [HD_W-1:0] handle;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_NONE = 2'd2
    } status_t;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_INS,
        S_UP_CMP,
        S_UP_FIN,
        S_POLL,
        S_DN_LAST,
        S_DN_CHK,
        S_DN_CMP,
        S_DN_MOVE,
        S_DONE
    } state_t;

    // Memory write request
    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] addr;
        entry_t           data;
    } wr_req_t;

endpackage

// ===== rtl/core/tmh_ram.sv =====
// Single-port-write, single-port-read heap storage with registered read data.
`timescale 1ns / 1ps
module tmh_ram
    import tmh_pkg::*;
(
    input  logic             aclk,
    input  wr_req_t          wr,
    input  logic [IDX_W-1:0] raddr,
    output entry_t           rdata
);

    entry_t mem [CAPACITY];
    entry_t rdata_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (wr.we) begin
            mem[wr.addr] <= wr.data;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/timer_event_min_heap_core.sv =====
// Top level of the timed-event queue: a 4-ary min-heap sequencer over one memory.
`timescale 1ns / 1ps
// Timed-event queue holding up to 64 (deadline, handle) entries in a 4-ary
// min-heap. An insert (tuser 0) stores now + delay, saturated to all ones,
// and sifts it toward the root; a poll (tuser 1) pops the root when its
// deadline is at or before now and sifts the last entry down from the root.
// Exactly one result leaves per item. Every heap access goes through a
// single memory read port with registered data and one shared 32-bit
// comparator, so the time an item takes follows the heap levels walked:
// an insert into an empty or a full queue walks none, any other insert
// reads and moves down one parent per level the entry rises; a poll that
// pops nothing or empties the queue walks none, any other poll reads the
// last entry, then per level scanned reads the children one at a time and
// moves the earliest one up if it is earlier, and writes where it settles.
// A finished result sits in an output register, so the next item is taken
// while it waits; if the previous result is still waiting when the next
// one is finished, the sequencer holds its last state until that transfer.
module timer_event_min_heap_core
    import tmh_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // s_tdata: now[31:0], delay[63:32], payload[79:64]
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,
    // s_tuser: kind[0]
    input  logic [0:0]  s_tuser,
    // m_tdata: due_payload[15:0], due_time[47:16], wake[48], pending[55:49]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,
    // m_tuser: status[1:0], fired[2]
    output logic [2:0]  m_tuser
);

    // Control state
    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] pos_reg, pos_next;
    logic [CH_W-1:0]  idx_reg, idx_next;
    logic [CH_W-1:0]  last_reg, last_next;
    logic [IDX_W-1:0] best_reg, best_next;
    logic             found_reg, found_next;
    logic             m_valid_reg, m_valid_next;

    // Datapath registers
    logic [DL_W-1:0]  now_reg, now_next;
    entry_t           item_reg, item_next;
    entry_t           best_ent_reg, best_ent_next;
    logic [DL_W-1:0]  cand_reg, cand_next;
    entry_t           root_reg;
    entry_t           pop_reg, pop_next;
    status_t          res_status_reg, res_status_next;
    logic             res_fired_reg, res_fired_next;
    logic             res_wake_reg, res_wake_next;
    logic [55:0]      m_data_reg, m_data_next;
    logic [2:0]       m_user_reg, m_user_next;

    // Memory interface
    wr_req_t          wr;
    logic [IDX_W-1:0] raddr;
    entry_t           rdata;

    // Shared comparator
    logic [DL_W-1:0]  cmp_a, cmp_b;
    logic             cmp_lt;

    // Input deadline with saturation
    logic [DL_W:0]    sum;
    logic [DL_W-1:0]  sat_dl;

    // Heap index helpers
    logic [IDX_W-1:0] parent;
    logic [IDX_W-1:0] grand;
    logic [CH_W-1:0]  first;
    logic [CH_W-1:0]  first_end;
    logic [CH_W-1:0]  count_ch;
    logic [DL_W-1:0]  due_time;

    tmh_ram u_ram (
        .aclk  (aclk),
        .wr    (wr),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign sum    = {1'b0, s_tdata[31:0]} + {1'b0, s_tdata[63:32]};
    assign sat_dl = sum[DL_W] ? {DL_W{1'b1}} : sum[DL_W-1:0];

    assign parent    = IDX_W'((pos_reg - IDX_W'(1)) / ARITY);
    assign grand     = IDX_W'((parent - IDX_W'(1)) / ARITY);
    assign first     = CH_W'(pos_reg) * CH_W'(ARITY) + CH_W'(1);
    assign first_end = first + CH_W'(ARITY);
    assign count_ch  = CH_W'(count_reg);

    assign cmp_lt = cmp_a < cmp_b;

    // Deadline reported with the result
    always_comb begin
        if (res_fired_reg) begin
            due_time = pop_reg.deadline;
        end else if (count_reg != '0) begin
            due_time = root_reg.deadline;
        end else begin
            due_time = '0;
        end
    end

    // Select comparator operands
    always_comb begin
        cmp_a = item_reg.deadline;
        cmp_b = root_reg.deadline;
        case (state_reg)
            S_POLL: begin
                cmp_a = now_reg;
                cmp_b = root_reg.deadline;
            end
            S_UP_CMP: begin
                cmp_a = item_reg.deadline;
                cmp_b = rdata.deadline;
            end
            S_DN_CMP: begin
                cmp_a = rdata.deadline;
                cmp_b = cand_reg;
            end
            default: begin
                cmp_a = item_reg.deadline;
                cmp_b = root_reg.deadline;
            end
        endcase
    end

    // State register and control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        pos_reg        <= pos_next;
        idx_reg        <= idx_next;
        last_reg       <= last_next;
        best_reg       <= best_next;
        found_reg      <= found_next;
        now_reg        <= now_next;
        item_reg       <= item_next;
        best_ent_reg   <= best_ent_next;
        cand_reg       <= cand_next;
        pop_reg        <= pop_next;
        res_status_reg <= res_status_next;
        res_fired_reg  <= res_fired_next;
        res_wake_reg   <= res_wake_next;
        m_data_reg     <= m_data_next;
        m_user_reg     <= m_user_next;
    end

    // Mirror the root slot
    always_ff @(posedge aclk) begin
        if (wr.we && wr.addr == '0) begin
            root_reg <= wr.data;
        end
    end

    // Next state and outputs
    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        pos_next        = pos_reg;
        idx_next        = idx_reg;
        last_next       = last_reg;
        best_next       = best_reg;
        found_next      = found_reg;
        m_valid_next    = m_valid_reg;
        now_next        = now_reg;
        item_next       = item_reg;
        best_ent_next   = best_ent_reg;
        cand_next       = cand_reg;
        pop_next        = pop_reg;
        res_status_next = res_status_reg;
        res_fired_next  = res_fired_reg;
        res_wake_next   = res_wake_reg;
        m_data_next     = m_data_reg;
        m_user_next     = m_user_reg;
        wr              = '0;
        raddr           = '0;
        s_tready        = 1'b0;

        // Drop the result once the transfer completes
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    now_next        = s_tdata[31:0];
                    item_next       = '{deadline: sat_dl, handle: s_tdata[79:64]};
                    res_status_next = ST_OK;
                    res_fired_next  = 1'b0;
                    res_wake_next   = 1'b0;
                    state_next      = (s_tuser[0] == KIND_POLL) ? S_POLL : S_INS;
                end
            end

            S_INS: begin
                if (count_reg >= CNT_W'(CAPACITY)) begin
                    res_status_next = ST_FULL;
                    state_next      = S_DONE;
                end else begin
                    res_wake_next = (count_reg == '0) || cmp_lt;
                    pos_next      = count_reg[IDX_W-1:0];
                    count_next    = count_reg + CNT_W'(1);
                    if (count_reg == '0) begin
                        wr         = '{we: 1'b1, addr: '0, data: item_reg};
                        state_next = S_DONE;
                    end else begin
                        raddr      = IDX_W'((count_reg[IDX_W-1:0] - IDX_W'(1)) / ARITY);
                        state_next = S_UP_CMP;
                    end
                end
            end

            // Move the parent down while it is later than the new entry
            S_UP_CMP: begin
                if (cmp_lt) begin
                    wr       = '{we: 1'b1, addr: pos_reg, data: rdata};
                    pos_next = parent;
                    if (parent == '0) begin
                        state_next = S_UP_FIN;
                    end else begin
                        raddr = grand;
                    end
                end else begin
                    wr         = '{we: 1'b1, addr: pos_reg, data: item_reg};
                    state_next = S_DONE;
                end
            end

            S_UP_FIN: begin
                wr         = '{we: 1'b1, addr: pos_reg, data: item_reg};
                state_next = S_DONE;
            end

            S_POLL: begin
                if (count_reg == '0 || cmp_lt) begin
                    res_status_next = ST_NONE;
                    state_next      = S_DONE;
                end else begin
                    res_fired_next = 1'b1;
                    pop_next       = root_reg;
                    count_next     = count_reg - CNT_W'(1);
                    if (count_reg == CNT_W'(1)) begin
                        state_next = S_DONE;
                    end else begin
                        raddr      = IDX_W'(count_reg - CNT_W'(1));
                        state_next = S_DN_LAST;
                    end
                end
            end

            // Take the last entry as the one moving down from the root
            S_DN_LAST: begin
                item_next  = rdata;
                pos_next   = '0;
                state_next = S_DN_CHK;
            end

            S_DN_CHK: begin
                if (first >= count_ch) begin
                    wr         = '{we: 1'b1, addr: pos_reg, data: item_reg};
                    state_next = S_DONE;
                end else begin
                    idx_next   = first;
                    last_next  = (first_end > count_ch) ? count_ch : first_end;
                    cand_next  = item_reg.deadline;
                    found_next = 1'b0;
                    raddr      = first[IDX_W-1:0];
                    state_next = S_DN_CMP;
                end
            end

            // Scan children one per read, keep the lowest strictly smaller one
            S_DN_CMP: begin
                if (cmp_lt) begin
                    cand_next     = rdata.deadline;
                    best_next     = idx_reg[IDX_W-1:0];
                    best_ent_next = rdata;
                    found_next    = 1'b1;
                end
                idx_next = idx_reg + CH_W'(1);
                if (idx_reg + CH_W'(1) < last_reg) begin
                    raddr = idx_next[IDX_W-1:0];
                end else begin
                    state_next = S_DN_MOVE;
                end
            end

            S_DN_MOVE: begin
                if (found_reg) begin
                    wr         = '{we: 1'b1, addr: pos_reg, data: best_ent_reg};
                    pos_next   = best_reg;
                    state_next = S_DN_CHK;
                end else begin
                    wr         = '{we: 1'b1, addr: pos_reg, data: item_reg};
                    state_next = S_DONE;
                end
            end

            // Load the output register when it is free
            S_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {count_reg, res_wake_reg, due_time,
                                    res_fired_reg ? pop_reg.handle : {HD_W{1'b0}}};
                    m_user_next  = {res_fired_reg, res_status_reg};
                    state_next   = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

// ===== sim/tb_timer_event_min_heap_core.sv =====
// Self-checking stream testbench for the 4-ary min-heap timed-event queue.
`timescale 1ns / 1ps
module tb_timer_event_min_heap_core;
    import tmh_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 60;
    localparam int MAX_SHOWN      = 10;

    // One result as it leaves the m_ channel
    typedef struct packed {
        status_t          status;
        logic             fired;
        logic [HD_W-1:0]  due_payload;
        logic [DL_W-1:0]  due_time;
        logic             wake;
        logic [CNT_W-1:0] pending;
    } outcome_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [79:0] s_tdata;
    logic [0:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;
    logic [2:0]  m_tuser;

    // Shadow copy of the heap, updated on every accepted input transfer
    logic [DL_W-1:0] shadow_deadline [CAPACITY];
    logic [HD_W-1:0] shadow_handle   [CAPACITY];
    int unsigned     shadow_count;
    outcome_t        expected_outcomes [$];

    bit          quiet_mode;
    int          sink_stall;
    int          idle_cycles;
    int          mismatch_count;
    logic [31:0] sim_clock;

    int n_insert, n_poll, n_fired, n_full, n_wake, n_nothing_due, peak_pending;

    timer_event_min_heap_core u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // 12 ns clock
    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    // Mostly back-to-back, some short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        if (quiet_mode)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    function automatic void heap_swap(int unsigned a, int unsigned b);
        logic [DL_W-1:0] d;
        logic [HD_W-1:0] h;
        d = shadow_deadline[a];
        h = shadow_handle[a];
        shadow_deadline[a] = shadow_deadline[b];
        shadow_handle[a]   = shadow_handle[b];
        shadow_deadline[b] = d;
        shadow_handle[b]   = h;
    endfunction

    // Move a new entry toward the root while its parent is strictly later
    function automatic void heap_raise(int unsigned pos);
        int unsigned parent;
        bit          done;
        done = 1'b0;
        while (!done && pos > 0) begin
            parent = (pos - 1) / ARITY;
            if (shadow_deadline[parent] > shadow_deadline[pos]) begin
                heap_swap(parent, pos);
                pos = parent;
            end else begin
                done = 1'b1;
            end
        end
    endfunction

    // Push the root down, swapping with the earliest strictly smaller child;
    // equal children resolve to the lowest index
    function automatic void heap_settle();
        int unsigned pos, first_child, last_child, best, i;
        bit          found, done;
        pos  = 0;
        done = 1'b0;
        while (!done) begin
            first_child = pos * ARITY + 1;
            if (first_child >= shadow_count) begin
                done = 1'b1;
            end else begin
                last_child = first_child + ARITY;
                if (last_child > shadow_count)
                    last_child = shadow_count;
                found = 1'b0;
                best  = 0;
                for (i = first_child; i < last_child; i++) begin
                    if (shadow_deadline[i] < shadow_deadline[pos] &&
                        (!found || shadow_deadline[i] < shadow_deadline[best])) begin
                        best  = i;
                        found = 1'b1;
                    end
                end
                if (!found) begin
                    done = 1'b1;
                end else begin
                    heap_swap(pos, best);
                    pos = best;
                end
            end
        end
    endfunction

    // Work out the result of one item and advance the shadow heap
    function automatic outcome_t predict_outcome(logic kind, logic [31:0] now,
                                                 logic [31:0] delay, logic [15:0] payload);
        outcome_t        res;
        logic [32:0]     sum;
        logic [DL_W-1:0] deadline;
        res = '0;
        res.status = ST_OK;
        if (kind == KIND_INSERT) begin
            if (shadow_count >= CAPACITY) begin
                res.status = ST_FULL;
            end else begin
                sum      = {1'b0, now} + {1'b0, delay};
                deadline = sum[32] ? '1 : sum[31:0];
                if (shadow_count == 0 || deadline < shadow_deadline[0])
                    res.wake = 1'b1;
                shadow_deadline[shadow_count] = deadline;
                shadow_handle[shadow_count]   = payload;
                heap_raise(shadow_count);
                shadow_count++;
            end
            if (shadow_count > 0)
                res.due_time = shadow_deadline[0];
        end else begin
            if (shadow_count > 0 && shadow_deadline[0] <= now) begin
                res.fired       = 1'b1;
                res.due_payload = shadow_handle[0];
                res.due_time    = shadow_deadline[0];
                shadow_count--;
                shadow_deadline[0] = shadow_deadline[shadow_count];
                shadow_handle[0]   = shadow_handle[shadow_count];
                heap_settle();
            end else begin
                res.status = ST_NONE;
                if (shadow_count > 0)
                    res.due_time = shadow_deadline[0];
            end
        end
        res.pending = shadow_count[CNT_W-1:0];
        return res;
    endfunction

    function automatic string fmt_outcome(outcome_t o);
        return $sformatf("status=%0d fired=%0d payload=%h due_time=%h wake=%0d pending=%0d",
                         o.status, o.fired, o.due_payload, o.due_time, o.wake, o.pending);
    endfunction

    // Drive one item after a random gap and hold it until the transfer
    task automatic send_item(input logic kind, input logic [31:0] now,
                             input logic [31:0] delay, input logic [15:0] payload);
        int       gap;
        outcome_t want;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge aclk);
            s_tvalid = 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid = 1'b1;
        s_tdata  = {payload, delay, now};
        s_tuser  = kind;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        want = predict_outcome(kind, now, delay, payload);
        expected_outcomes.push_back(want);
        if (kind == KIND_INSERT) n_insert++;
        else n_poll++;
        if (want.fired) n_fired++;
        if (want.wake) n_wake++;
        if (want.status == ST_FULL) n_full++;
        if (want.status == ST_NONE) n_nothing_due++;
        if (shadow_count > peak_pending) peak_pending = shadow_count;
    endtask

    task automatic insert_event(input logic [31:0] now, input logic [31:0] delay,
                                input logic [15:0] payload);
        send_item(KIND_INSERT, now, delay, payload);
    endtask

    // Poll with random noise on the fields that a poll ignores
    task automatic poll_event(input logic [31:0] now);
        send_item(KIND_POLL, now, $urandom(), 16'($urandom_range(0, 65535)));
    endtask

    // Compare every result transfer with the oldest expectation
    always @(posedge aclk) begin
        outcome_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got.due_payload = m_tdata[15:0];
            got.due_time    = m_tdata[47:16];
            got.wake        = m_tdata[48];
            got.pending     = m_tdata[55:49];
            got.status      = status_t'(m_tuser[1:0]);
            got.fired       = m_tuser[2];
            if (expected_outcomes.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_SHOWN)
                    $display("[%0t] unexpected result: %s", $realtime, fmt_outcome(got));
            end else begin
                want = expected_outcomes.pop_front();
                if (got.status !== want.status || got.fired !== want.fired ||
                    got.due_payload !== want.due_payload || got.due_time !== want.due_time ||
                    got.wake !== want.wake || got.pending !== want.pending) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_SHOWN) begin
                        $display("[%0t] mismatch expected: %s", $realtime, fmt_outcome(want));
                        $display("[%0t]            actual: %s", $realtime, fmt_outcome(got));
                    end
                end
            end
        end
    end

    // Stall the result side at random, except in quiet stretches
    initial begin
        m_tready   = 1'b0;
        sink_stall = 0;
        forever begin
            @(negedge aclk);
            if (sink_stall > 0 && !quiet_mode) begin
                m_tready = 1'b0;
                sink_stall--;
            end else begin
                m_tready   = 1'b1;
                sink_stall = 0;
                if ($urandom_range(0, 3) == 0)
                    sink_stall = pick_gap();
            end
        end
    end

    // Abort when no transfer happens on either side for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("timer_event_min_heap_core verification failed");
                $finish;
            end
        end
    end

    // Polls on an empty queue
    task automatic test_empty_queue();
        poll_event(32'h0000_0000);
        poll_event(32'hFFFF_FFFF);
    endtask

    // Saturation, exact top, zero deadlines, equal-root insert, due boundary
    task automatic test_deadline_extremes();
        insert_event(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
        insert_event(32'h0000_0000, 32'h0000_0000, 16'h0000);
        insert_event(32'h7FFF_FFFF, 32'h8000_0000, 16'h5A5A);
        insert_event(32'h8000_0000, 32'h8000_0000, 16'hA5A5);
        insert_event(32'h0000_0000, 32'h0000_0000, 16'h1234);
        poll_event(32'h0000_0000);
        poll_event(32'h0000_0000);
        poll_event(32'hFFFF_FFFE);
        poll_event(32'hFFFF_FFFF);
        poll_event(32'hFFFF_FFFF);
        poll_event(32'hFFFF_FFFF);
        poll_event(32'hFFFF_FFFF);
    endtask

    // Sift-down among equal children picks the lowest index
    task automatic test_child_tie_break();
        insert_event(32'd0, 32'd10, 16'h0010);
        insert_event(32'd0, 32'd30, 16'h0030);
        insert_event(32'd0, 32'd20, 16'h0021);
        insert_event(32'd0, 32'd20, 16'h0022);
        insert_event(32'd0, 32'd25, 16'h0025);
        insert_event(32'd0, 32'd40, 16'h0040);
        poll_event(32'd10);
        poll_event(32'd19);
        repeat (5) poll_event(32'd100);
    endtask

    // Random inserts and polls against an advancing time base
    task automatic test_mixed_traffic(input int n_items, input logic [31:0] start_clock);
        int          r;
        logic [31:0] now, delay;
        sim_clock = start_clock;
        repeat (n_items) begin
            r = $urandom_range(0, 99);
            if (r < 55) begin
                now = ($urandom_range(0, 19) == 0) ? $urandom() : sim_clock;
                r   = $urandom_range(0, 99);
                if (r < 70)
                    delay = $urandom_range(0, 50);
                else if (r < 85)
                    delay = $urandom_range(0, 1000);
                else if (r < 95)
                    delay = $urandom();
                else
                    delay = 32'hFFFF_0000 | $urandom_range(0, 65535);
                insert_event(now, delay, 16'($urandom_range(0, 65535)));
            end else begin
                sim_clock = sim_clock + $urandom_range(0, 20);
                now = ($urandom_range(0, 19) == 0) ? $urandom() : sim_clock;
                poll_event(now);
            end
        end
    endtask

    // Fill to capacity, push into the full queue, then drain near the root deadline
    task automatic test_fill_and_drain(input int rounds, input int delay_span);
        logic [31:0] now, root;
        int          r;
        repeat (rounds) begin
            while (shadow_count < CAPACITY)
                insert_event(sim_clock, $urandom_range(0, delay_span),
                             16'($urandom_range(0, 65535)));
            insert_event(sim_clock, $urandom_range(0, delay_span),
                         16'($urandom_range(0, 65535)));
            insert_event($urandom(), $urandom(), 16'($urandom_range(0, 65535)));
            while (shadow_count > 0) begin
                root = shadow_deadline[0];
                r    = $urandom_range(0, 9);
                if (r < 2 && root != 0)
                    now = root - 1;
                else if (r < 5)
                    now = root;
                else
                    now = (root > 32'hFFFF_FFF0) ? 32'hFFFF_FFFF : root + $urandom_range(0, 8);
                poll_event(now);
            end
            poll_event(sim_clock);
            sim_clock = sim_clock + $urandom_range(0, 1000);
        end
    endtask

    initial begin
        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = KIND_INSERT;
        quiet_mode     = 1'b0;
        shadow_count   = 0;
        mismatch_count = 0;
        sim_clock      = '0;
        n_insert = 0; n_poll = 0; n_fired = 0; n_full = 0;
        n_wake = 0; n_nothing_due = 0; peak_pending = 0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_empty_queue();
        test_deadline_extremes();
        test_child_tie_break();
        test_mixed_traffic(550, 32'd0);
        test_fill_and_drain(2, 200);
        test_fill_and_drain(1, 3);
        quiet_mode = 1'b1;
        test_mixed_traffic(400, 32'h0010_0000);
        quiet_mode = 1'b0;
        test_mixed_traffic(300, 32'hFFFF_FF00);

        // Release the input, let outstanding results drain, then watch for strays
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (expected_outcomes.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("Covered %0d inserts (%0d woke, %0d rejected full), %0d polls",
                 n_insert, n_wake, n_full, n_poll);
        $display("  (%0d fired, %0d nothing due), peak depth %0d, %0d mismatches",
                 n_fired, n_nothing_due, peak_pending, mismatch_count);
        if (mismatch_count == 0)
            $display("timer_event_min_heap_core verification clean");
        else
            $display("timer_event_min_heap_core verification failed");
        $finish;
    end

endmodule
